FILE: src/cpc_pkg.sv
package cpc_pkg;

   localparam int OPND_W       = 32;
   localparam int PROD_W       = 63;
   localparam int ZW           = 34;
   localparam int RW           = 50;
   localparam int MW           = RW + 1;
   localparam int REDUCE_STEPS = 13;
   localparam int REDUCE_PRE_SH = 30 - REDUCE_STEPS;
   localparam int ANGLE_SH     = 14;
   localparam int WRAP_SH      = 16;

   localparam logic signed [ZW-1:0]     HALF_PI_Q30 = 34'sd1686629713;
   localparam logic [RW-1:0]            PI_Q46      = 50'h0C90FDAA22168;
   localparam logic [RW-1:0]            TWO_PI_Q46  = 50'h1921FB54442D1;
   localparam logic signed [OPND_W-1:0] PI_Q16      = 32'sd205887;
   localparam logic signed [OPND_W-1:0] Q16_MAX     = 32'sh7FFF_FFFF;
   localparam logic signed [OPND_W-1:0] Q16_MIN     = 32'sh8000_0000;

   localparam logic MODE_TO_POLAR     = 1'b0;
   localparam logic MODE_TO_CARTESIAN = 1'b1;
   localparam logic OP_STORE          = 1'b0;
   localparam logic OP_EVAL           = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_LOAD_Y,
      ST_REDUCE,
      ST_WRAP,
      ST_PREROT,
      ST_ROTATE,
      ST_PACK
   } cpc_state_type;

   typedef struct packed {
      logic load_first;
      logic mul_first;
      logic mul_second;
      logic load_y;
      logic reduce_step;
      logic wrap;
      logic prerotate;
      logic rotate;
      logic pack;
   } cpc_cmd_type;

   typedef struct packed {
      logic reduce_last;
      logic rotate_last;
      logic out_free;
   } cpc_status_type;

   function automatic logic [63:0] gain_sum(input int iterations);
      logic [63:0] p;
      p = 64'd1 << 30;
      for (int i = 0; i < 16; i++) begin
         if (i < iterations) begin
            p = p + (p >> (2 * i));
         end
      end
      return p;
   endfunction

   function automatic logic [63:0] isqrt(input logic [63:0] n);
      logic [63:0] rem_v;
      logic [63:0] res;
      logic [63:0] bit_v;
      rem_v = n;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (rem_v >= res + bit_v) begin
            rem_v = rem_v - (res + bit_v);
            res   = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
      logic signed [ZW-1:0] a;
      unique case (i)
         5'd0: begin
            a = 34'sd843314856;
         end
         5'd1: begin
            a = 34'sd497837829;
         end
         5'd2: begin
            a = 34'sd263043836;
         end
         5'd3: begin
            a = 34'sd133525158;
         end
         5'd4: begin
            a = 34'sd67021686;
         end
         5'd5: begin
            a = 34'sd33543515;
         end
         5'd6: begin
            a = 34'sd16775850;
         end
         5'd7: begin
            a = 34'sd8388437;
         end
         5'd8: begin
            a = 34'sd4194282;
         end
         5'd9: begin
            a = 34'sd2097149;
         end
         5'd31: begin
            a = '0;
         end
         default: begin
            a = (34'sd1 <<< (5'd30 - i)) - 34'sd1;
         end
      endcase
      return a;
   endfunction

endpackage

FILE: src/cpc_ctrl.sv
module cpc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_op,
   input  logic                    conversion_mode,
   input  cpc_pkg::cpc_status_type status,
   output logic                    req_stall,
   output cpc_pkg::cpc_cmd_type    cmd
);
   import cpc_pkg::*;

   cpc_state_type state_ff;
   cpc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_op == OP_EVAL)) begin
               cmd.load_first = 1'b1;
               state_in       = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            cmd.mul_first = 1'b1;
            state_in      = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.mul_second = 1'b1;
            if (conversion_mode == MODE_TO_POLAR) begin
               state_in = ST_LOAD_Y;
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_LOAD_Y: begin
            cmd.load_y = 1'b1;
            state_in   = ST_PREROT;
         end
         ST_REDUCE: begin
            cmd.reduce_step = 1'b1;
            if (status.reduce_last) begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            cmd.wrap = 1'b1;
            state_in = ST_PREROT;
         end
         ST_PREROT: begin
            cmd.prerotate = 1'b1;
            state_in      = ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            if (status.rotate_last) begin
               state_in = ST_PACK;
            end
         end
         ST_PACK: begin
            if (status.out_free) begin
               cmd.pack = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

FILE: src/cpc_datapath.sv
module cpc_datapath #(
   parameter int DATA_WIDTH = 32,
   parameter int ITERATIONS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  conversion_mode,
   input  logic signed [cpc_pkg::OPND_W-1:0]     first_operand,
   input  logic signed [cpc_pkg::OPND_W-1:0]     second_operand,
   input  cpc_pkg::cpc_cmd_type                  cmd,
   output cpc_pkg::cpc_status_type               status,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic signed [cpc_pkg::OPND_W-1:0]     rsp_first_result,
   output logic signed [cpc_pkg::OPND_W-1:0]     rsp_second_result
);
   import cpc_pkg::*;

   localparam int VW       = DATA_WIDTH + 2;
   localparam int SCALE_SH = 62 - DATA_WIDTH;
   localparam int IW       = $clog2(ITERATIONS);
   localparam int CW       = (IW > 4) ? IW : 4;
   localparam int SHR      = (DATA_WIDTH > 32) ? DATA_WIDTH - 32 : 0;
   localparam int SHL      = (DATA_WIDTH < 32) ? 32 - DATA_WIDTH : 0;
   localparam int QW       = VW + 1 + SHL;

   localparam logic [63:0] GAIN_SUM  = gain_sum(ITERATIONS);
   localparam logic [63:0] GAIN_ROOT = isqrt(GAIN_SUM << 30);
   localparam logic [63:0] GAIN_FULL = (64'd1 << 60) / GAIN_ROOT;
   localparam logic [29:0] GAIN_K    = GAIN_FULL[29:0];

   localparam logic signed [PROD_W-1:0] SCALE_RND = PROD_W'(1) <<< (SCALE_SH - 1);
   localparam logic signed [QW-1:0]     Q16_RND   = QW'((2 ** SHR) / 2);
   localparam logic signed [ZW:0]       ANG_RND   = (ZW + 1)'(1) <<< (ANGLE_SH - 1);

   logic signed [OPND_W-1:0] first_ff, first_in;
   logic                     zero_ff, zero_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [VW-1:0]     x_ff, x_in;
   logic signed [VW-1:0]     y_ff, y_in;
   logic signed [ZW-1:0]     z_ff, z_in;
   logic [RW-1:0]            rem_ff, rem_in;
   logic                     neg_ff, neg_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OPND_W-1:0] rsp_first_ff, rsp_first_in;
   logic signed [OPND_W-1:0] rsp_second_ff, rsp_second_in;

   logic signed [OPND_W-1:0] mul_a;
   logic signed [30:0]       mul_k;
   logic signed [PROD_W-1:0] prod_round;
   logic [OPND_W:0]          opnd_mag;
   logic [RW-1:0]            rem_dbl;
   logic [RW-1:0]            mod_pos;
   logic signed [MW-1:0]     mod_s;
   logic signed [MW-1:0]     mod_wrap;
   logic [IW-1:0]            idx;
   logic signed [VW-1:0]     sx, sy;
   logic signed [ZW-1:0]     atan_v;
   logic                     rot_pos;
   logic signed [ZW:0]       ang_w;
   logic signed [OPND_W-1:0] ang_q16;

   function automatic logic signed [OPND_W-1:0] to_q16(input logic signed [VW-1:0] v);
      logic signed [QW-1:0] w;
      w = ((QW'(v) + Q16_RND) >>> SHR) <<< SHL;
      if (w > QW'(Q16_MAX)) begin
         return Q16_MAX;
      end else if (w < QW'(Q16_MIN)) begin
         return Q16_MIN;
      end else begin
         return w[OPND_W-1:0];
      end
   endfunction

   assign mul_a      = cmd.mul_first ? first_ff : second_operand;
   assign mul_k      = $signed({1'b0, GAIN_K});
   assign prod_round = (prod_ff + SCALE_RND) >>> SCALE_SH;
   assign opnd_mag   = second_operand[OPND_W-1] ? ((OPND_W + 1)'(0) - {1'b1, second_operand})
                                                : {1'b0, second_operand};
   assign rem_dbl    = rem_ff << 1;
   assign mod_pos    = (neg_ff && (rem_ff != '0)) ? (TWO_PI_Q46 - rem_ff) : rem_ff;
   assign mod_s      = $signed({1'b0, mod_pos});
   assign mod_wrap   = (mod_pos >= PI_Q46) ? (mod_s - $signed({1'b0, TWO_PI_Q46})) : mod_s;
   assign idx        = cnt_ff[IW-1:0];
   assign sx         = x_ff >>> idx;
   assign sy         = y_ff >>> idx;
   assign atan_v     = atan_q30(5'(idx));
   assign rot_pos    = (conversion_mode == MODE_TO_POLAR) ? (y_ff > 0) : (z_ff < 0);
   assign ang_w      = ((ZW + 1)'(z_ff) + ANG_RND) >>> ANGLE_SH;

   always_comb begin
      if (ang_w > (ZW + 1)'(PI_Q16)) begin
         ang_q16 = PI_Q16;
      end else if (ang_w < -((ZW + 1)'(PI_Q16))) begin
         ang_q16 = -PI_Q16;
      end else begin
         ang_q16 = ang_w[OPND_W-1:0];
      end
   end

   always_comb begin
      first_in      = first_ff;
      zero_in       = zero_ff;
      prod_in       = prod_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.load_first) begin
         first_in = first_operand;
         zero_in  = (first_operand == '0) && (second_operand == '0);
      end

      if (cmd.mul_first || cmd.mul_second) begin
         prod_in = mul_a * mul_k;
      end

      if (cmd.mul_second) begin
         x_in   = prod_round[VW-1:0];
         rem_in = RW'(opnd_mag) << REDUCE_PRE_SH;
         neg_in = second_operand[OPND_W-1];
         cnt_in = '0;
      end

      if (cmd.load_y) begin
         y_in = prod_round[VW-1:0];
         z_in = '0;
      end

      if (cmd.reduce_step) begin
         rem_in = (rem_dbl >= TWO_PI_Q46) ? (rem_dbl - TWO_PI_Q46) : rem_dbl;
         cnt_in = cnt_ff + CW'(1);
      end

      if (cmd.wrap) begin
         z_in = ZW'(mod_wrap >>> WRAP_SH);
         y_in = '0;
      end

      if (cmd.prerotate) begin
         cnt_in = '0;
         if (conversion_mode == MODE_TO_POLAR) begin
            if (x_ff < 0) begin
               if (y_ff >= 0) begin
                  x_in = y_ff;
                  y_in = -x_ff;
                  z_in = HALF_PI_Q30;
               end else begin
                  x_in = -y_ff;
                  y_in = x_ff;
                  z_in = -HALF_PI_Q30;
               end
            end
         end else begin
            if (z_ff > HALF_PI_Q30) begin
               y_in = x_ff;
               x_in = '0;
               z_in = z_ff - HALF_PI_Q30;
            end else if (z_ff < -HALF_PI_Q30) begin
               y_in = -x_ff;
               x_in = '0;
               z_in = z_ff + HALF_PI_Q30;
            end
         end
      end

      if (cmd.rotate) begin
         cnt_in = cnt_ff + CW'(1);
         if (rot_pos) begin
            x_in = x_ff + sy;
            y_in = y_ff - sx;
            z_in = z_ff + atan_v;
         end else begin
            x_in = x_ff - sy;
            y_in = y_ff + sx;
            z_in = z_ff - atan_v;
         end
      end

      if (cmd.pack) begin
         rsp_valid_in = 1'b1;
         if (conversion_mode == MODE_TO_POLAR) begin
            rsp_first_in  = zero_ff ? '0 : to_q16(x_ff);
            rsp_second_in = zero_ff ? '0 : ang_q16;
         end else begin
            rsp_first_in  = to_q16(x_ff);
            rsp_second_in = to_q16(y_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff      <= first_in;
      zero_ff       <= zero_in;
      prod_ff       <= prod_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

   assign status.reduce_last = (cnt_ff == CW'(REDUCE_STEPS - 1));
   assign status.rotate_last = (cnt_ff == CW'(ITERATIONS - 1));
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_result  = rsp_first_ff;
   assign rsp_second_result = rsp_second_ff;

endmodule

FILE: src/cartesian_polar_converter.sv
// Iterative CORDIC converter on signed Q16.16 values. csr_wr_data selects the
// mode: 0 converts cartesian to polar (magnitude and atan2 angle in -pi..pi),
// 1 converts polar to cartesian (amplitude times cosine and sine, the angle
// first reduced modulo 2*pi). A request transaction with req_op = 0 stores
// req_value as the second operand (y, or the angle) and gives no response;
// with req_op = 1 it brings the first operand (x, or the amplitude) and
// yields one response transaction. Results that overflow saturate. The
// shared CORDIC stage runs one micro-rotation per cycle; in polar to
// cartesian mode a shift-and-subtract unit reduces the angle first. Store
// transactions leave the block idle. The request side stalls while an
// evaluation runs; a finished response waits in an output register while
// the next request is taken. Write the mode only while the block is idle.
module cartesian_polar_converter #(
   parameter int DATA_WIDTH = 32,
   parameter int ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_first_result,
   output logic signed [31:0] rsp_second_result
);
   import cpc_pkg::*;

   logic                     mode_ff;
   logic signed [OPND_W-1:0] second_ff;
   logic                     req_accept;
   cpc_cmd_type              cmd;
   cpc_status_type           status;

   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_TO_POLAR;
         second_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (req_accept && (req_op == OP_STORE)) begin
            second_ff <= req_value;
         end
      end
   end

   cpc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_op          (req_op),
      .conversion_mode (mode_ff),
      .status          (status),
      .req_stall       (req_stall),
      .cmd             (cmd)
   );

   cpc_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .ITERATIONS (ITERATIONS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .conversion_mode   (mode_ff),
      .first_operand     (req_value),
      .second_operand    (second_ff),
      .cmd               (cmd),
      .status            (status),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_first_result  (rsp_first_result),
      .rsp_second_result (rsp_second_result)
   );

endmodule
